### src/grt_pkg.sv
// Package for the guest region table.
// Holds the field widths and the operation and status codes; all other files import it.
package grt_pkg;

    localparam int OP_W     = 2;
    localparam int ADDR_W   = 64;
    localparam int LEN_W    = 64;
    localparam int STATUS_W = 2;
    localparam int BASE_W   = 40;
    localparam int PIDX_W   = 28;
    localparam int POFF_W   = 12;
    localparam int BUDGET_W = 41;

    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 41'h100_0000_0000;

    localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BUDGET  = 2'd3;

endpackage

### src/grt_in_if.sv
// Input channel of the guest region table: operation, address and length.
// Depends on grt_pkg for the field widths.
interface grt_in_if
    import grt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;

    modport source (output valid, output operation, output address, output length,
                    input ready);
    modport sink   (input valid, input operation, input address, input length,
                    output ready);
endinterface

### src/grt_out_if.sv
// Result channel of the guest region table.
// Depends on grt_pkg for the field widths.
interface grt_out_if
    import grt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [BASE_W-1:0]   hit_region_base;
    logic [PIDX_W-1:0]   page_index;
    logic [POFF_W-1:0]   page_offset;

    modport source (output valid, output status, output found, output hit_region_base,
                    output page_index, output page_offset, input ready);
    modport sink   (input valid, input status, input found, input hit_region_base,
                    input page_index, input page_offset, output ready);
endinterface

### src/guest_region_table.sv
// Guest region table: lookups and adds that pass the early checks are worked through a scan
// of the region memory through its single read port, one entry a cycle.
// Releases and items that fail the early checks skip the scan. One item is worked at a time;
// the next item is taken while a finished result still waits in the output register.
// Reset empties the table and sets the budget to 2^40 bytes; no clearing pass is needed.
// Depends on grt_pkg, grt_in_if and grt_out_if.
module guest_region_table
    import grt_pkg::*;
#(
    parameter int REGIONS   = 16,
    parameter int PAGE_BITS = 12,
    parameter int GPA_BITS  = 40
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [BUDGET_W-1:0] cfg_wr_data,
    grt_in_if.sink              in_item,
    grt_out_if.source           out_item
);

    localparam int SP = GPA_BITS - PAGE_BITS;
    localparam int MW = 2 * SP + 1;
    localparam int IW = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int CW = $clog2(REGIONS + 1);
    localparam logic [ADDR_W-1:0] PAGE_MASK = (64'd1 << PAGE_BITS) - 64'd1;
    localparam logic [ADDR_W:0]   GPA_LIMIT = 65'd1 << GPA_BITS;

    typedef enum logic [1:0] {S_IDLE, S_CHECK, S_SCAN, S_FINISH} state_t;

    // Control registers.
    state_t               state_reg, state_next;
    logic [REGIONS-1:0]   valid_reg, valid_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [BUDGET_W-1:0]  bytes_reg, bytes_next;
    logic [BUDGET_W-1:0]  budget_reg, budget_next;
    logic [CW-1:0]        rd_cnt_reg, rd_cnt_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic                 out_valid_reg, out_valid_next;

    // Payload registers.
    logic [OP_W-1:0]      op_reg, op_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [SP-1:0]        first_reg, first_next;
    logic [SP:0]          end_reg, end_next;
    logic                 in_range_reg, in_range_next;
    logic [IW-1:0]        cmp_idx_reg, cmp_idx_next;
    logic                 overlap_reg, overlap_next;
    logic                 slot_found_reg, slot_found_next;
    logic [IW-1:0]        slot_reg, slot_next;
    logic                 hit_reg, hit_next;
    logic [SP-1:0]        hit_start_reg, hit_start_next;
    logic [SP-1:0]        hit_pidx_reg, hit_pidx_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic                 out_found_reg, out_found_next;
    logic [BASE_W-1:0]    out_base_reg, out_base_next;
    logic [PIDX_W-1:0]    out_pidx_reg, out_pidx_next;
    logic [POFF_W-1:0]    out_poff_reg, out_poff_next;

    // Region memory: start page and page count of each entry.
    logic [MW-1:0]        mem [REGIONS];
    logic [MW-1:0]        rd_data_reg;
    logic                 rd_en;
    logic [IW-1:0]        rd_idx;
    logic                 mem_we;
    logic [MW-1:0]        mem_wdata;

    logic                 accept;
    logic                 addr_hi_bad;
    logic                 unaligned;
    logic [ADDR_W:0]      addr_sum;
    logic [BUDGET_W-1:0]  budget_left;
    logic [SP-1:0]        ent_start;
    logic [SP:0]          ent_count;
    logic [SP:0]          ent_end;
    logic                 ent_valid;
    logic [ADDR_W-1:0]    base_wide;
    logic [ADDR_W-1:0]    pidx_wide;
    logic [ADDR_W-1:0]    poff_wide;

    assign accept       = in_item.valid && in_item.ready;
    assign in_item.ready = (state_reg == S_IDLE);

    assign addr_hi_bad = (addr_reg >> GPA_BITS) != 64'd0;
    assign unaligned   = (len_reg == 64'd0) || (((addr_reg | len_reg) & PAGE_MASK) != 64'd0);
    assign addr_sum    = {1'b0, addr_reg} + {1'b0, len_reg};
    assign budget_left = budget_reg - bytes_reg;

    assign rd_idx    = rd_cnt_reg[IW-1:0];
    assign ent_start = rd_data_reg[MW-1:SP+1];
    assign ent_count = rd_data_reg[SP:0];
    assign ent_end   = {1'b0, ent_start} + ent_count;
    assign ent_valid = valid_reg[cmp_idx_reg];

    assign base_wide = ADDR_W'(hit_start_reg) << PAGE_BITS;
    assign pidx_wide = ADDR_W'(hit_pidx_reg);
    assign poff_wide = ADDR_W'(addr_reg[PAGE_BITS-1:0]);
    assign mem_wdata = {first_reg, len_reg[GPA_BITS:PAGE_BITS]};

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        bytes_next      = bytes_reg;
        budget_next     = budget_reg;
        rd_cnt_next     = rd_cnt_reg;
        cmp_valid_next  = 1'b0;
        out_valid_next  = out_valid_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        len_next        = len_reg;
        status_next     = status_reg;
        first_next      = first_reg;
        end_next        = end_reg;
        in_range_next   = in_range_reg;
        cmp_idx_next    = cmp_idx_reg;
        overlap_next    = overlap_reg;
        slot_found_next = slot_found_reg;
        slot_next       = slot_reg;
        hit_next        = hit_reg;
        hit_start_next  = hit_start_reg;
        hit_pidx_next   = hit_pidx_reg;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_base_next   = out_base_reg;
        out_pidx_next   = out_pidx_reg;
        out_poff_next   = out_poff_reg;
        rd_en           = 1'b0;
        mem_we          = 1'b0;

        if (cfg_wr_en)
        begin
            budget_next = cfg_wr_data;
        end
        if (out_valid_reg && out_item.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = in_item.operation;
                    addr_next  = in_item.address;
                    len_next   = in_item.length;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                first_next      = addr_reg[GPA_BITS-1:PAGE_BITS];
                end_next        = {1'b0, addr_reg[GPA_BITS-1:PAGE_BITS]}
                                  + len_reg[GPA_BITS:PAGE_BITS];
                in_range_next   = !addr_hi_bad;
                rd_cnt_next     = '0;
                overlap_next    = 1'b0;
                slot_found_next = 1'b0;
                hit_next        = 1'b0;
                case (op_reg)
                    OP_ADD:
                    begin
                        state_next = S_FINISH;
                        if (unaligned || addr_hi_bad || (addr_sum > GPA_LIMIT))
                        begin
                            status_next = ST_INVALID;
                        end
                        else if (count_reg >= CW'(REGIONS))
                        begin
                            status_next = ST_FULL;
                        end
                        else if ((bytes_reg > budget_reg) || (len_reg > LEN_W'(budget_left)))
                        begin
                            status_next = ST_BUDGET;
                        end
                        else
                        begin
                            status_next = ST_OK;
                            state_next  = S_SCAN;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        status_next = ST_INVALID;
                        state_next  = S_SCAN;
                    end
                    OP_RELEASE:
                    begin
                        status_next = ST_OK;
                        state_next  = S_FINISH;
                    end
                    default:
                    begin
                        status_next = ST_INVALID;
                        state_next  = S_FINISH;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (rd_cnt_reg != CW'(REGIONS))
                begin
                    rd_en          = 1'b1;
                    rd_cnt_next    = rd_cnt_reg + CW'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_idx;
                end
                if (cmp_valid_reg)
                begin
                    if (op_reg == OP_ADD)
                    begin
                        if (ent_valid && ({1'b0, first_reg} < ent_end)
                            && ({1'b0, ent_start} < end_reg))
                        begin
                            overlap_next = 1'b1;
                        end
                        if (!ent_valid && !slot_found_reg)
                        begin
                            slot_found_next = 1'b1;
                            slot_next       = cmp_idx_reg;
                        end
                    end
                    else if (ent_valid && in_range_reg && !hit_reg
                             && (first_reg >= ent_start) && ({1'b0, first_reg} < ent_end))
                    begin
                        hit_next       = 1'b1;
                        hit_start_next = ent_start;
                        hit_pidx_next  = first_reg - ent_start;
                    end
                    if (cmp_idx_reg == IW'(REGIONS - 1))
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_item.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_found_next  = 1'b0;
                    out_base_next   = '0;
                    out_pidx_next   = '0;
                    out_poff_next   = '0;
                    state_next      = S_IDLE;
                    case (op_reg)
                        OP_ADD:
                        begin
                            if (status_reg == ST_OK)
                            begin
                                if (overlap_reg)
                                begin
                                    out_status_next = ST_INVALID;
                                end
                                else if (!slot_found_reg)
                                begin
                                    out_status_next = ST_FULL;
                                end
                                else
                                begin
                                    out_found_next        = 1'b1;
                                    mem_we                = 1'b1;
                                    valid_next[slot_reg]  = 1'b1;
                                    count_next            = count_reg + CW'(1);
                                    bytes_next            = bytes_reg + len_reg[BUDGET_W-1:0];
                                end
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if (hit_reg)
                            begin
                                out_status_next = ST_OK;
                                out_found_next  = 1'b1;
                                out_base_next   = base_wide[BASE_W-1:0];
                                out_pidx_next   = pidx_wide[PIDX_W-1:0];
                                out_poff_next   = poff_wide[POFF_W-1:0];
                            end
                        end
                        OP_RELEASE:
                        begin
                            out_found_next = 1'b1;
                            valid_next     = '0;
                            count_next     = '0;
                            bytes_next     = '0;
                        end
                        default:
                        begin
                            out_status_next = ST_INVALID;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            count_reg     <= '0;
            bytes_reg     <= '0;
            budget_reg    <= BUDGET_RESET;
            rd_cnt_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            bytes_reg     <= bytes_next;
            budget_reg    <= budget_next;
            rd_cnt_reg    <= rd_cnt_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        len_reg        <= len_next;
        status_reg     <= status_next;
        first_reg      <= first_next;
        end_reg        <= end_next;
        in_range_reg   <= in_range_next;
        cmp_idx_reg    <= cmp_idx_next;
        overlap_reg    <= overlap_next;
        slot_found_reg <= slot_found_next;
        slot_reg       <= slot_next;
        hit_reg        <= hit_next;
        hit_start_reg  <= hit_start_next;
        hit_pidx_reg   <= hit_pidx_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_base_reg   <= out_base_next;
        out_pidx_reg   <= out_pidx_next;
        out_poff_reg   <= out_poff_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[slot_reg] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign out_item.valid           = out_valid_reg;
    assign out_item.status          = out_status_reg;
    assign out_item.found           = out_found_reg;
    assign out_item.hit_region_base = out_base_reg;
    assign out_item.page_index      = out_pidx_reg;
    assign out_item.page_offset     = out_poff_reg;

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CW'($countones(valid_reg)))
        else $error("Region count differs from the number of valid entries.");

    a_empty_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (bytes_reg == '0))
        else $error("Bytes in use with an empty table.");

    a_write_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !valid_reg[slot_reg])
        else $error("Region written over a valid entry.");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_FINISH))
        else $error("Result raised outside the finish state.");
`endif

endmodule
